// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the glyph atlas placer.
// No dependencies; included by gar_chk.sv, which holds the concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GAR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gar_chk: property failed");

// Next-cycle implication, disabled while reset is low.
`define GAR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gar_chk: property failed");

`endif

// ===== sv/gar_pkg.sv =====
// Package for the glyph atlas rectangle placer: widths, reset values,
// register and status codes, sequencer states and beat structs. No dependencies.
package gar_pkg;

  localparam int MAX_DIM_DEF    = 1024;
  localparam int CODE_COUNT_DEF = 256;

  localparam int CODE_W  = 8;
  localparam int SIZE_W  = 10;
  localparam int POS_W   = 10;
  localparam int AW_W    = 11;
  localparam int GAP_W   = 4;
  localparam int ALIGN_W = 9;
  localparam int PASS_W  = 14;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [AW_W-1:0]    ATLAS_W_RST = 11'd1024;
  localparam logic [AW_W-1:0]    ATLAS_H_RST = 11'd1024;
  localparam logic [GAP_W-1:0]   GAP_RST     = 4'd2;
  localparam logic [ALIGN_W-1:0] ALIGN_RST   = 9'd64;
  localparam logic [PASS_W-1:0]  PASSES_RST  = 14'd10000;

  // Register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_ATLAS_W,
    REG_ATLAS_H,
    REG_GAP,
    REG_ALIGN,
    REG_PASSES
  } gar_reg_e;

  typedef enum logic [1:0] {
    ST_PLACED,
    ST_PRESENT,
    ST_NOSPACE
  } gar_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_EVAL,
    S_WRAP,
    S_FIT
  } gar_state_e;

  typedef struct packed {
    logic signed [CODE_W-1:0] glyph_code;
    logic [SIZE_W-1:0]        glyph_width;
    logic [SIZE_W-1:0]        glyph_height;
  } gar_req_t;

  typedef struct packed {
    gar_status_e       status;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
  } gar_res_t;

  typedef struct packed {
    logic [AW_W-1:0]    atlas_width;
    logic [AW_W-1:0]    atlas_height;
    logic [GAP_W-1:0]   gap_pixels;
    logic [ALIGN_W-1:0] row_align;
    logic [PASS_W-1:0]  max_passes;
  } gar_cfg_t;

endpackage

// ===== sv/gar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the placed-entry table.
module gar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/gar_rem.sv =====
// Bit-serial restoring remainder unit; returns the value rounded up to the
// next multiple of the divisor (an exact multiple gains a full step). Uses gar_pkg.
module gar_rem #(
  parameter int CW = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CW-1:0]               dividend_i,
  input  logic [gar_pkg::ALIGN_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [CW-1:0]               value_o
);
  import gar_pkg::*;

  localparam int CNT_W = $clog2(CW + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]      num_q, num_d;
  logic [CW-1:0]      shf_q, shf_d;
  logic [ALIGN_W-1:0] div_q, div_d;
  logic [ALIGN_W-1:0] rem_q, rem_d;
  logic [ALIGN_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    shf_d  = shf_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, shf_q[CW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(CW);
      num_d  = dividend_i;
      shf_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // one quotient bit per cycle
      if (trial >= {1'b0, div_q}) begin
        rem_d = ALIGN_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = ALIGN_W'(trial);
      end
      shf_d = {shf_q[CW-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    shf_q <= shf_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o  = done_q;
  assign value_o = num_q + CW'(div_q) - CW'(rem_q);

endmodule

// ===== sv/gar_cfg.sv =====
// APB-style configuration registers of the glyph atlas placer.
// Uses gar_pkg for register indexes, widths and reset values.
module gar_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gar_pkg::ADDR_W-1:0] paddr,
  input  logic [gar_pkg::DATA_W-1:0] pwdata,
  output logic [gar_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output gar_pkg::gar_cfg_t          cfg_o
);
  import gar_pkg::*;

  gar_cfg_t cfg_q;
  gar_reg_e reg_idx;
  logic     wr;

  assign pready  = 1'b1;
  assign reg_idx = gar_reg_e'(paddr[ADDR_W-1:2]);
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atlas_width  <= ATLAS_W_RST;
      cfg_q.atlas_height <= ATLAS_H_RST;
      cfg_q.gap_pixels   <= GAP_RST;
      cfg_q.row_align    <= ALIGN_RST;
      cfg_q.max_passes   <= PASSES_RST;
    end else if (wr) begin
      case (reg_idx)
        REG_ATLAS_W: cfg_q.atlas_width  <= pwdata[AW_W-1:0];
        REG_ATLAS_H: cfg_q.atlas_height <= pwdata[AW_W-1:0];
        REG_GAP:     cfg_q.gap_pixels   <= pwdata[GAP_W-1:0];
        REG_ALIGN:   cfg_q.row_align    <= pwdata[ALIGN_W-1:0];
        REG_PASSES:  cfg_q.max_passes   <= pwdata[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ATLAS_W: prdata = DATA_W'(cfg_q.atlas_width);
      REG_ATLAS_H: prdata = DATA_W'(cfg_q.atlas_height);
      REG_GAP:     prdata = DATA_W'(cfg_q.gap_pixels);
      REG_ALIGN:   prdata = DATA_W'(cfg_q.row_align);
      REG_PASSES:  prdata = DATA_W'(cfg_q.max_passes);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/glyph_atlas_rect_placer.sv =====
// Top level of the glyph atlas rectangle placer: sequencer, valid bits,
// entry table. Depends on gar_pkg, gar_cfg, gar_ram and gar_rem.
//
// Usage: a request beat (code, width, height) is taken on start while busy is
// low. busy stays high until the answer; the result beat shows on result_o
// for one cycle with done_o and cannot be held off by the receiver.
// Already-present codes and codes beyond the table answer from the lookup
// state through the registered done_o. A placement scans the table one slot a
// cycle while the slots are empty; each valid entry adds a registered table
// read and an evaluation, and each wrap to a new row runs the remainder unit
// (of width CW = $clog2(MAX_DIM + 528)) before the scan goes on. Passes
// repeat until one moves nothing, up to max_passes.
// Configuration is written over the APB-style port while idle: a rule for
// the user, which the block itself does not enforce.
// Reset clears the valid bits at once (no clearing pass) and loads the
// register defaults; the table contents need no reset.
module glyph_atlas_rect_placer #(
  parameter int MAX_DIM    = gar_pkg::MAX_DIM_DEF,
  parameter int CODE_COUNT = gar_pkg::CODE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  gar_pkg::gar_req_t          req_i,
  output logic                       done_o,
  output gar_pkg::gar_res_t          result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gar_pkg::ADDR_W-1:0] paddr,
  input  logic [gar_pkg::DATA_W-1:0] pwdata,
  output logic [gar_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import gar_pkg::*;

  localparam int DW     = $clog2(MAX_DIM);
  localparam int CW     = $clog2(MAX_DIM + 528);
  localparam int SW     = ((CW > AW_W) ? CW : AW_W) + 1;
  localparam int SLOT_W = $clog2(CODE_COUNT);
  localparam int EW     = 4 * DW;
  localparam logic [SW-1:0] MAX_DIM_S = SW'(MAX_DIM);

  gar_cfg_t cfg;

  gar_state_e        state_q, state_d;
  gar_req_t          req_q;
  logic [CW-1:0]     cx_q, cx_d, cy_q, cy_d;
  logic [SLOT_W:0]   idx_q, idx_d;
  logic [PASS_W-1:0] pass_q, pass_d, pass_inc;
  logic              settled_q, settled_d;
  logic [CODE_COUNT-1:0] valid_q;
  logic              any_q;
  logic              done_q, done_d;
  gar_res_t          res_q, res_d;
  logic              accept, set_valid;

  logic [CODE_W-1:0] slot_raw;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot;

  logic              rd_en, wr_en;
  logic [EW-1:0]     rd_data, wr_data;

  logic              rem_start, rem_done;
  logic [CW-1:0]     rem_value;
  logic [ALIGN_W-1:0] align;

  logic [SW-1:0] aw, ah, gap_s, sx, sy, cx_s, cy_s, cxe, cye;
  logic [SW-1:0] ex0, ey0, x1g, y1g, nx;
  logic          ovx, ovy, hit, wrap, fits;

  gar_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gar_ram #(
    .WIDTH (EW),
    .DEPTH (CODE_COUNT)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[SLOT_W-1:0]),
    .rd_data_o (rd_data)
  );

  gar_rem #(
    .CW (CW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (CW'(y1g)),
    .divisor_i  (align),
    .done_o     (rem_done),
    .value_o    (rem_value)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // slot order follows signed code: slot = code + 128
  assign slot_raw = req_q.glyph_code ^ CODE_W'(8'h80);
  assign slot_ok  = {1'b0, slot_raw} < (CODE_W + 1)'(CODE_COUNT);
  assign slot     = slot_raw[SLOT_W-1:0];

  assign aw    = (SW'(cfg.atlas_width) > MAX_DIM_S) ? MAX_DIM_S : SW'(cfg.atlas_width);
  assign ah    = (SW'(cfg.atlas_height) > MAX_DIM_S) ? MAX_DIM_S : SW'(cfg.atlas_height);
  assign align = (cfg.row_align == '0) ? ALIGN_W'(1) : cfg.row_align;
  assign gap_s = SW'(cfg.gap_pixels);
  assign sx    = SW'(req_q.glyph_width);
  assign sy    = SW'(req_q.glyph_height);
  assign cx_s  = SW'(cx_q);
  assign cy_s  = SW'(cy_q);
  assign cxe   = cx_s + sx;
  assign cye   = cy_s + sy;

  // entry layout {x0, y0, x1, y1}
  assign ex0 = SW'(rd_data[4*DW-1 -: DW]);
  assign ey0 = SW'(rd_data[3*DW-1 -: DW]);
  assign x1g = SW'(rd_data[2*DW-1 -: DW]) + gap_s;
  assign y1g = SW'(rd_data[DW-1:0]) + gap_s;

  // only the candidate's edges are tested against the entry span
  assign ovx  = (cx_s >= ex0 && cx_s < x1g) || (cxe >= ex0 && cxe < x1g);
  assign ovy  = (cy_s >= ey0 && cy_s < y1g) || (cye >= ey0 && cye < y1g);
  assign hit  = ovx && ovy;
  assign nx   = hit ? x1g : cx_s;
  assign wrap = (nx + sx) >= aw;
  assign fits = (cye < ah) && (cxe < aw);

  assign pass_inc = pass_q + PASS_W'(1);
  assign wr_data  = {DW'(cx_q), DW'(cy_q), DW'(cxe), DW'(cye)};

  always_comb begin
    state_d   = state_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    idx_d     = idx_q;
    pass_d    = pass_q;
    settled_d = settled_q;
    done_d    = 1'b0;
    res_d     = '0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    set_valid = 1'b0;
    rem_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cx_d    = '0;
          cy_d    = '0;
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!slot_ok) begin
          res_d.status = ST_NOSPACE;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (valid_q[slot]) begin
          res_d.status = ST_PRESENT;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (!any_q || cfg.max_passes == '0) begin
          state_d = S_FIT;
        end else begin
          idx_d     = '0;
          pass_d    = '0;
          settled_d = 1'b1;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == (SLOT_W + 1)'(CODE_COUNT)) begin
          pass_d = pass_inc;
          if (settled_q || pass_inc >= cfg.max_passes) begin
            state_d = S_FIT;
          end else begin
            idx_d     = '0;
            settled_d = 1'b1;
          end
        end else if (valid_q[idx_q[SLOT_W-1:0]]) begin
          rd_en   = 1'b1;
          state_d = S_EVAL;
        end else begin
          idx_d = idx_q + (SLOT_W + 1)'(1);
        end
      end
      S_EVAL: begin
        if (hit || wrap) begin
          settled_d = 1'b0;
        end
        if (wrap) begin
          cx_d      = '0;
          rem_start = 1'b1;
          state_d   = S_WRAP;
        end else begin
          cx_d    = CW'(nx);
          idx_d   = idx_q + (SLOT_W + 1)'(1);
          state_d = S_SCAN;
        end
      end
      S_WRAP: begin
        if (rem_done) begin
          cy_d    = rem_value;
          idx_d   = idx_q + (SLOT_W + 1)'(1);
          state_d = S_SCAN;
        end
      end
      S_FIT: begin
        if (fits) begin
          wr_en        = 1'b1;
          set_valid    = 1'b1;
          res_d.status = ST_PLACED;
          res_d.pos_x  = POS_W'(cx_q);
          res_d.pos_y  = POS_W'(cy_q);
        end else begin
          res_d.status = ST_NOSPACE;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      pass_q    <= '0;
      settled_q <= 1'b0;
      valid_q   <= '0;
      any_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pass_q    <= pass_d;
      settled_q <= settled_d;
      done_q    <= done_d;
      if (set_valid) begin
        valid_q[slot] <= 1'b1;
        any_q         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== sv/gar_chk.sv =====
// Port-level checker for the glyph atlas placer, bound to the top level.
// Depends on gar_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gar_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input gar_pkg::gar_res_t result_o
);
  import gar_pkg::*;

  `GAR_ASSERT_NXT(a_accept_goes_busy, clk_i, rst_ni, start && !busy, busy)
  `GAR_ASSERT_IMP(a_done_ends_work, clk_i, rst_ni, done_o, $past(busy) && !busy)
  `GAR_ASSERT_IMP(a_status_legal, clk_i, rst_ni, done_o, result_o.status == ST_PLACED || result_o.status == ST_PRESENT || result_o.status == ST_NOSPACE)
  `GAR_ASSERT_IMP(a_pos_zero_unplaced, clk_i, rst_ni, done_o && result_o.status != ST_PLACED, result_o.pos_x == '0 && result_o.pos_y == '0)

endmodule

bind glyph_atlas_rect_placer gar_chk u_gar_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== bench/tb_glyph_atlas_rect_placer.sv =====
// Self-checking bench for glyph_atlas_rect_placer: a shadow placement table
// predicts every answer beat, compared field by field as it leaves the block.
// Depends on gar_pkg and the placer RTL.

class atlas_board;
  bit   live [gar_pkg::CODE_COUNT_DEF];
  int   x0 [gar_pkg::CODE_COUNT_DEF];
  int   y0 [gar_pkg::CODE_COUNT_DEF];
  int   x1 [gar_pkg::CODE_COUNT_DEF];
  int   y1 [gar_pkg::CODE_COUNT_DEF];

  logic [gar_pkg::AW_W-1:0]    atlas_w;
  logic [gar_pkg::AW_W-1:0]    atlas_h;
  logic [gar_pkg::GAP_W-1:0]   gap;
  logic [gar_pkg::ALIGN_W-1:0] align;
  logic [gar_pkg::PASS_W-1:0]  pass_cap;

  gar_pkg::gar_res_t answers_due[$];
  int mismatches;

  function new();
    atlas_w    = gar_pkg::ATLAS_W_RST;
    atlas_h    = gar_pkg::ATLAS_H_RST;
    gap        = gar_pkg::GAP_RST;
    align      = gar_pkg::ALIGN_RST;
    pass_cap   = gar_pkg::PASSES_RST;
    mismatches = 0;
  endfunction

  function void report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  function void set_reg(gar_pkg::gar_reg_e idx, logic [gar_pkg::DATA_W-1:0] v);
    case (idx)
      gar_pkg::REG_ATLAS_W: atlas_w  = v[gar_pkg::AW_W-1:0];
      gar_pkg::REG_ATLAS_H: atlas_h  = v[gar_pkg::AW_W-1:0];
      gar_pkg::REG_GAP:     gap      = v[gar_pkg::GAP_W-1:0];
      gar_pkg::REG_ALIGN:   align    = v[gar_pkg::ALIGN_W-1:0];
      gar_pkg::REG_PASSES:  pass_cap = v[gar_pkg::PASS_W-1:0];
      default: ;
    endcase
  endfunction

  // table slots run in signed-code order: code -128 is slot 0
  function int slot_of(gar_pkg::gar_req_t r);
    return int'({~r.glyph_code[gar_pkg::CODE_W-1], r.glyph_code[gar_pkg::CODE_W-2:0]});
  endfunction

  function int clip(logic [gar_pkg::AW_W-1:0] v);
    return (int'(v) > gar_pkg::MAX_DIM_DEF) ? gar_pkg::MAX_DIM_DEF : int'(v);
  endfunction

  function int live_count();
    int n;
    n = 0;
    foreach (live[i]) if (live[i]) n++;
    return n;
  endfunction

  function bit in_span(int v, int lo, int hi);
    return v >= lo && v < hi;
  endfunction

  // Refinement passes over the placed entries; give_up bounds the passes
  // walked when only a cost estimate is wanted.
  function void find_spot(gar_pkg::gar_req_t r, int give_up,
                          output int cx, output int cy,
                          output int passes, output int wraps);
    int sx, sy, aw, g, al;
    bit settled, ovx, ovy;
    sx = int'(r.glyph_width);
    sy = int'(r.glyph_height);
    aw = clip(atlas_w);
    g  = int'(gap);
    al = (align == '0) ? 1 : int'(align);
    cx = 0;
    cy = 0;
    passes = 0;
    wraps  = 0;
    if (live_count() != 0) begin
      settled = 1'b0;
      while (!settled && passes < int'(pass_cap) && passes < give_up) begin
        settled = 1'b1;
        passes++;
        for (int i = 0; i < gar_pkg::CODE_COUNT_DEF; i++) begin
          if (live[i]) begin
            // only the candidate's edges are tested, containment slips through
            ovx = in_span(cx, x0[i], x1[i] + g) || in_span(cx + sx, x0[i], x1[i] + g);
            ovy = in_span(cy, y0[i], y1[i] + g) || in_span(cy + sy, y0[i], y1[i] + g);
            if (ovx && ovy) begin
              cx = x1[i] + g;
              settled = 1'b0;
            end
            if (cx + sx >= aw) begin
              cx = 0;
              cy = y1[i] + g;
              cy += al - (cy % al);
              settled = 1'b0;
              wraps++;
            end
          end
        end
      end
    end
  endfunction

  function bit fits_budget(gar_pkg::gar_req_t r, int budget);
    int cx, cy, p, w, n;
    if (slot_of(r) >= gar_pkg::CODE_COUNT_DEF || live[slot_of(r)]) return 1'b1;
    n = live_count();
    find_spot(r, budget / (gar_pkg::CODE_COUNT_DEF + 1) + 1, cx, cy, p, w);
    return 8 + p * (gar_pkg::CODE_COUNT_DEF + 1 + n) + w * 24 < budget;
  endfunction

  function void take_request(gar_pkg::gar_req_t r);
    gar_pkg::gar_res_t a;
    int s, cx, cy, p, w;
    a.status = gar_pkg::ST_NOSPACE;
    a.pos_x  = '0;
    a.pos_y  = '0;
    s = slot_of(r);
    if (s < gar_pkg::CODE_COUNT_DEF) begin
      if (live[s]) begin
        a.status = gar_pkg::ST_PRESENT;
      end else begin
        find_spot(r, 32'h7fff_ffff, cx, cy, p, w);
        // touching the far edge counts as not fitting
        if (cy + int'(r.glyph_height) < clip(atlas_h) &&
            cx + int'(r.glyph_width) < clip(atlas_w)) begin
          live[s] = 1'b1;
          x0[s] = cx;
          y0[s] = cy;
          x1[s] = cx + int'(r.glyph_width);
          y1[s] = cy + int'(r.glyph_height);
          a.status = gar_pkg::ST_PLACED;
          a.pos_x  = cx[gar_pkg::POS_W-1:0];
          a.pos_y  = cy[gar_pkg::POS_W-1:0];
        end
      end
    end
    answers_due.push_back(a);
  endfunction

  function void check_answer(gar_pkg::gar_res_t got);
    gar_pkg::gar_res_t want;
    if (answers_due.size() == 0) begin
      report($sformatf("answer beat with none outstanding (status %0d)", got.status));
      return;
    end
    want = answers_due.pop_front();
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.pos_x !== want.pos_x)
      report($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
    if (got.pos_y !== want.pos_y)
      report($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
  endfunction

  function void drain_check();
    if (answers_due.size() != 0)
      report($sformatf("%0d answer beats never arrived", answers_due.size()));
  endfunction
endclass

module tb_glyph_atlas_rect_placer;
  import gar_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int BUDGET          = 30000;  // cycles allowed for one request

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  gar_req_t          req_i   = '0;
  logic              done_o;
  gar_res_t          result_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  atlas_board board = new();
  bit         burst;

  glyph_atlas_rect_placer uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_answer(result_o);
  end

  initial begin
    #400_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // back-to-back writes keep psel high; the caller drops it after the last one
  task automatic apb_write(gar_reg_e idx, logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, v);
  endtask

  // every request answers, so idle means nothing outstanding and busy low
  task automatic settle();
    start <= 1'b0;
    while (board.answers_due.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(int aw, int ah, int gp, int al, int mp);
    settle();
    apb_write(REG_ATLAS_W, DATA_W'(aw));
    apb_write(REG_ATLAS_H, DATA_W'(ah));
    apb_write(REG_GAP,     DATA_W'(gp));
    apb_write(REG_ALIGN,   DATA_W'(al));
    apb_write(REG_PASSES,  DATA_W'(mp));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_setup();
    int aw, ah, al, mp;
    case ($urandom_range(4))
      0:       aw = 1;
      1:       aw = 1024;
      2:       aw = $urandom_range(2047, 1025);
      default: aw = $urandom_range(1024, 64);
    endcase
    case ($urandom_range(4))
      0:       ah = 1;
      1:       ah = 1024;
      2:       ah = $urandom_range(2047, 1025);
      default: ah = $urandom_range(1024, 64);
    endcase
    case ($urandom_range(5))
      0:       al = 0;
      1:       al = 256;
      2:       al = 511;
      3:       al = 1;
      default: al = $urandom_range(128, 2);
    endcase
    case ($urandom_range(5))
      0:       mp = 0;
      1:       mp = 16383;
      default: mp = $urandom_range(8, 1);
    endcase
    configure(aw, ah, $urandom_range(15), al, mp);
  endtask

  // start is only touched once per time step: lowered for a gap, else left high
  task automatic send(gar_req_t r, int unsigned idle);
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    board.take_request(r);
  endtask

  function automatic gar_req_t glyph(int code, int w, int h);
    gar_req_t r;
    r.glyph_code   = code[CODE_W-1:0];
    r.glyph_width  = w[SIZE_W-1:0];
    r.glyph_height = h[SIZE_W-1:0];
    return r;
  endfunction

  function automatic gar_req_t draw_glyph();
    gar_req_t    r;
    int unsigned c;
    int          w, h;
    c = $urandom;
    // mostly codes not yet placed, so the table keeps growing
    if ($urandom_range(3) != 0)
      for (int k = 0; k < 16 && board.live[c % CODE_COUNT_DEF]; k++) c = $urandom;
    case ($urandom_range(9))
      6, 7: begin
        w = $urandom_range(255);
        h = $urandom_range(255);
      end
      8: begin
        w = $urandom_range(1023);
        h = $urandom_range(1023);
      end
      9: begin
        w = $urandom_range(1) ? 1023 : 0;
        h = $urandom_range(1) ? 1023 : 0;
      end
      default: begin
        w = $urandom_range(40);
        h = $urandom_range(40);
      end
    endcase
    return glyph(int'(c % CODE_COUNT_DEF) - 128, w, h);
  endfunction

  // redraw requests whose pass count would run away; a placed code is cheap
  function automatic gar_req_t next_glyph();
    gar_req_t r;
    r = draw_glyph();
    for (int k = 0; k < 20 && !board.fits_budget(r, BUDGET); k++) r = draw_glyph();
    if (!board.fits_budget(r, BUDGET)) begin
      for (int i = 0; i < CODE_COUNT_DEF; i++)
        if (board.live[i]) r.glyph_code = CODE_W'(i - 128);
    end
    return r;
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty table, repeat code, wrap with containment, full width
    send(glyph(-128, 0, 0), $urandom_range(18));
    send(glyph(-128, 0, 0), $urandom_range(18));
    send(glyph(0, 10, 10), $urandom_range(18));
    send(glyph(127, 1023, 1023), $urandom_range(18));
    send(glyph(1, 1023, 0), $urandom_range(18));

    // no passes; oversize atlas clips to the max dimension
    configure(2047, 2047, 15, 0, 0);
    send(glyph(2, 3, 3), $urandom_range(18));
    send(glyph(3, 1023, 0), $urandom_range(18));

    // edge touching is a miss on either axis
    configure(20, 20, 15, 0, 0);
    send(glyph(4, 20, 0), $urandom_range(18));
    send(glyph(5, 19, 19), $urandom_range(18));
    send(glyph(6, 0, 20), $urandom_range(18));

    configure(1, 1, 15, 0, 0);
    send(glyph(7, 0, 0), $urandom_range(18));
    send(glyph(8, 1, 0), $urandom_range(18));

    configure(1024, 1024, 0, 256, 16383);
    send(glyph(9, 0, 0), $urandom_range(18));
    send(glyph(10, 100, 30), $urandom_range(18));
    send(glyph(11, 1000, 10), $urandom_range(18));

    // unit alignment: every wrap lands on an exact multiple and gains a row
    configure(1024, 1024, 0, 1, 4);
    send(glyph(12, 1023, 0), $urandom_range(18));
    send(glyph(127, 0, 0), $urandom_range(18));

    for (int ph = 0; ph < PHASES; ph++) begin
      random_setup();
      burst = ($urandom_range(3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send(next_glyph(), burst ? 0 : $urandom_range(18));
    end

    settle();
    repeat (50) @(posedge clk_i);
    board.drain_check();
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/gar_pkg.sv
sv/gar_ram.sv
sv/gar_rem.sv
sv/gar_cfg.sv
sv/glyph_atlas_rect_placer.sv
sv/gar_chk.sv
bench/tb_glyph_atlas_rect_placer.sv
